>>> hdl/mtbr_pkg.sv
// Package: constants, types and functions shared by the bounded MT19937 unit.
`default_nettype none

package mtbr_pkg;

    localparam int unsigned MtN   = 624;
    localparam int unsigned MtM   = 397;
    localparam int unsigned AddrW = $clog2(MtN);
    localparam int unsigned WordW = 32;
    localparam int unsigned CntW  = $clog2(WordW);

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [WordW-1:0] t_word;
    typedef logic [CntW-1:0]  t_cnt;

    localparam t_word MtMatrix  = 32'h9908_b0df;
    localparam t_word MtUpper   = 32'h8000_0000;
    localparam t_word MtLower   = 32'h7fff_ffff;
    localparam t_word TemperB   = 32'h9d2c_5680;
    localparam t_word TemperC   = 32'hefc6_0000;
    localparam t_word SeedMult  = 32'd69069;
    localparam t_word SeedReset = 32'd1923879;

    localparam t_addr LastAddr = t_addr'(MtN - 1);
    localparam t_addr FarStep  = t_addr'(MtM);
    localparam t_addr WrapStep = t_addr'(MtN - MtM);
    localparam t_cnt  LastStep = t_cnt'(WordW - 1);

    typedef enum logic [2:0] {
        G_FILL,
        G_IDLE,
        G_RD0,
        G_RD1,
        G_RD2
    } t_gen_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_DIV,
        S_DONE
    } t_top_state;

    typedef struct packed {
        logic  idle;
        logic  valid;
        t_word word;
    } t_gen_rsp;

    typedef struct packed {
        logic  done;
        t_word rem;
    } t_div_rsp;

    function automatic t_word twist(input t_word cur, input t_word nxt, input t_word far);
        t_word y;
        y = (cur & MtUpper) | (nxt & MtLower);
        return far ^ (y >> 1) ^ (y[0] ? MtMatrix : '0);
    endfunction

    function automatic t_word temper(input t_word x);
        t_word v;
        v = x ^ (x >> 11);
        v = v ^ ((v << 7) & TemperB);
        v = v ^ ((v << 15) & TemperC);
        v = v ^ (v >> 18);
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mtbr_if.sv
// Valid/ready channel interfaces for requests, responses and seed writes.
`default_nettype none

interface mtbr_bound_if;
    logic            valid;
    logic            ready;
    mtbr_pkg::t_word bound;
    modport source (output valid, output bound, input ready);
    modport sink (input valid, input bound, output ready);
endinterface

interface mtbr_value_if;
    logic            valid;
    logic            ready;
    mtbr_pkg::t_word value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface mtbr_seed_if;
    logic            valid;
    logic            ready;
    mtbr_pkg::t_word seed;
    modport source (output valid, output seed, input ready);
    modport sink (input valid, input seed, output ready);
endinterface

`default_nettype wire

>>> hdl/mtbr_mem.sv
// Twister state RAM: 624 x 32, one write port, one registered read port.
`default_nettype none

module mtbr_mem (
    input  wire              i_clk,
    input  wire              i_we,
    input  mtbr_pkg::t_addr  i_waddr,
    input  mtbr_pkg::t_word  i_wdata,
    input  wire              i_re,
    input  mtbr_pkg::t_addr  i_raddr,
    output mtbr_pkg::t_word  o_rdata
);
    import mtbr_pkg::*;

    t_word r_mem [MtN];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/mtbr_gen.sv
// Word generator: seed fill sweep and per-word lazy twist with tempering.
`default_nettype none

module mtbr_gen (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_seed_we,
    input  mtbr_pkg::t_word    i_seed,
    input  wire                i_draw,
    output mtbr_pkg::t_gen_rsp o_rsp
);
    import mtbr_pkg::*;

    t_gen_state r_state, n_state;
    t_addr      r_idx, n_idx;
    t_addr      r_fill, n_fill;
    t_word      r_acc, n_acc;
    logic       r_word_valid, n_word_valid;
    t_word      r_word, n_word;
    t_word      r_cur;
    t_word      r_nxt;

    logic       mem_we;
    t_addr      mem_waddr;
    t_word      mem_wdata;
    logic       mem_re;
    t_addr      mem_raddr;
    t_word      mem_rdata;

    t_addr      next_addr;
    t_addr      far_addr;
    t_word      new_word;

    mtbr_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign next_addr = (r_idx == LastAddr) ? '0 : r_idx + 1'b1;
    assign far_addr  = (r_idx >= WrapStep) ? r_idx - WrapStep : r_idx + FarStep;
    // entries below r_idx already hold this round's values, so far reads see the right word
    assign new_word  = twist(r_cur, r_nxt, mem_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= G_FILL;
            r_idx        <= '0;
            r_fill       <= '0;
            r_acc        <= SeedReset;
            r_word_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_fill       <= n_fill;
            r_acc        <= n_acc;
            r_word_valid <= n_word_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (r_state == G_RD0) begin
            r_cur <= mem_rdata;
        end
        if (r_state == G_RD1) begin
            r_nxt <= mem_rdata;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_fill       = r_fill;
        n_acc        = r_acc;
        n_word_valid = 1'b0;
        n_word       = r_word;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = new_word;
        mem_re       = 1'b0;
        mem_raddr    = r_idx;
        case (r_state)
            G_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_fill;
                mem_wdata = r_acc;
                n_acc     = r_acc * SeedMult;
                if (r_fill == LastAddr) begin
                    n_state = G_IDLE;
                    n_idx   = '0;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            G_IDLE: begin
                if (i_draw) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx;
                    n_state   = G_RD0;
                end
            end
            G_RD0: begin
                mem_re    = 1'b1;
                mem_raddr = next_addr;
                n_state   = G_RD1;
            end
            G_RD1: begin
                mem_re    = 1'b1;
                mem_raddr = far_addr;
                n_state   = G_RD2;
            end
            G_RD2: begin
                mem_we       = 1'b1;
                mem_waddr    = r_idx;
                n_word       = temper(new_word);
                n_word_valid = 1'b1;
                n_idx        = next_addr;
                n_state      = G_IDLE;
            end
            default: begin
                n_state = G_FILL;
                n_fill  = '0;
            end
        endcase
        if (i_seed_we) begin
            n_state      = G_FILL;
            n_fill       = '0;
            n_acc        = i_seed;
            n_word_valid = 1'b0;
        end
    end

    assign o_rsp.idle  = (r_state == G_IDLE);
    assign o_rsp.valid = r_word_valid;
    assign o_rsp.word  = r_word;

endmodule

`default_nettype wire

>>> hdl/mtbr_div.sv
// Radix-2 restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module mtbr_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  mtbr_pkg::t_word    i_dividend,
    input  mtbr_pkg::t_word    i_divisor,
    output mtbr_pkg::t_div_rsp o_rsp
);
    import mtbr_pkg::*;

    logic             r_busy;
    logic             r_done;
    t_cnt             r_cnt;
    t_word            r_rem;
    t_word            r_dvd;
    t_word            r_dvs;

    logic [WordW:0]   part;
    logic [WordW:0]   diff;
    t_word            step_rem;

    assign part     = {r_rem, r_dvd[WordW-1]};
    assign diff     = part - {1'b0, r_dvs};
    assign step_rem = diff[WordW] ? part[WordW-1:0] : diff[WordW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= step_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> hdl/mersenne_twister_bounded_random_unit.sv
// Top level: bounded MT19937 random unit with request, response and seed channels.
//
// i_req carries a bound per request; o_rsp returns one value per request.
// A bound of zero returns one tempered 32-bit word. Any other bound returns a
// value uniform in [0, bound), drawn by rejection: a word v is redrawn while
// v - (v mod bound) + bound exceeds 2^32, then v mod bound is returned.
// i_cfg writes the seed; it is always ready.
// After reset and after every seed transfer the state RAM is filled from the
// seed by the 69069 recurrence, one word per cycle, and i_req is not ready
// until the fill is done.
// Each drawn word is a state RAM read-modify-write: three reads on the single
// read port, then the write back. A bounded draw adds a pass of the serial
// remainder unit per word drawn, fewer than two words on average. One request
// is in work at a time.
// Results wait in an output register; when the receiver stalls, the finished
// request holds there and the next request waits once its result is ready.
`default_nettype none

module mersenne_twister_bounded_random_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mtbr_bound_if.sink   i_req,
    mtbr_value_if.source o_rsp,
    mtbr_seed_if.sink    i_cfg
);
    import mtbr_pkg::*;

    t_top_state      r_state, n_state;
    t_word           r_bound, n_bound;
    t_word           r_cand, n_cand;
    t_word           r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_word           r_out_value, n_out_value;

    logic            in_ready;
    logic            out_free;
    logic            draw;
    logic            div_start;
    logic            seed_we;
    logic            reject;
    logic [WordW:0]  lead;

    t_gen_rsp        gen_rsp;
    t_div_rsp        div_rsp;

    assign seed_we = i_cfg.valid;

    mtbr_gen u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (seed_we),
        .i_seed    (i_cfg.seed),
        .i_draw    (draw),
        .o_rsp     (gen_rsp)
    );

    mtbr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gen_rsp.word),
        .i_divisor  (r_bound),
        .o_rsp      (div_rsp)
    );

    assign lead   = {1'b0, r_cand - div_rsp.rem} + {1'b0, r_bound};
    assign reject = lead[WordW] && (lead[WordW-1:0] != '0);

    assign in_ready = (r_state == S_IDLE) && gen_rsp.idle;
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound     <= n_bound;
        r_cand      <= n_cand;
        r_res       <= n_res;
        r_out_value <= n_out_value;
    end

    always_comb begin
        n_state     = r_state;
        n_bound     = r_bound;
        n_cand      = r_cand;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_value = r_out_value;
        draw        = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && in_ready) begin
                    n_bound = i_req.bound;
                    draw    = 1'b1;
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (gen_rsp.valid) begin
                    if (r_bound == '0) begin
                        n_res   = gen_rsp.word;
                        n_state = S_DONE;
                    end else begin
                        n_cand    = gen_rsp.word;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (reject) begin
                        draw    = 1'b1;
                        n_state = S_DRAW;
                    end else begin
                        n_res   = div_rsp.rem;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

endmodule

`default_nettype wire

>>> hdl/mtbr_chk.sv
// Port-level assertion checker for the bounded MT19937 unit, with its bind.
`default_nettype none

module mtbr_chk (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_req_valid,
    input wire             i_req_ready,
    input wire             i_rsp_valid,
    input wire             i_rsp_ready,
    input mtbr_pkg::t_word i_rsp_value,
    input wire             i_cfg_valid,
    input wire             i_cfg_ready
);

    a_fill_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request ready right after reset");

    a_fill_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_ready) |=> !i_req_ready)
        else $error("request ready right after seed transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("second request taken while one is in work");

    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_value)))
        else $error("stalled response changed");

endmodule

bind mersenne_twister_bounded_random_unit mtbr_chk u_mtbr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.value),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the bounded MT19937 unit: drives requests and seed writes, predicts every value.
`default_nettype none

module tb_top;

    typedef mtbr_pkg::t_word t_word;

    localparam int    CLK_PERIOD  = 12;
    localparam int    STATE_WORDS = 624;
    localparam int    TAP_OFFSET  = 397;
    localparam t_word MULT_69069  = 32'd69069;
    localparam t_word TWIST_XOR   = 32'h9908_b0df;
    localparam t_word HIGH_BIT    = 32'h8000_0000;
    localparam t_word LOW_BITS    = 32'h7fff_ffff;
    localparam t_word TEMPER_B    = 32'h9d2c_5680;
    localparam t_word TEMPER_C    = 32'hefc6_0000;
    localparam t_word RESET_SEED  = 32'd1923879;
    localparam int    HOLD_CYCLES = 400;
    localparam int    DRAIN_LIMIT = 50000;
    localparam int    TAIL_CYCLES = 80;
    localparam int    PHASE_ITEMS = 300;

    logic i_clk;
    logic i_rst_n;

    mtbr_bound_if req_if ();
    mtbr_value_if rsp_if ();
    mtbr_seed_if  cfg_if ();

    mersenne_twister_bounded_random_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    t_word       mt_words [STATE_WORDS];
    int unsigned mt_next;
    t_word       awaited_values [$];
    int          err_count    = 0;
    int          src_idle_pct = 12;
    int          snk_idle_pct = 50;
    logic        hold_start   = 1'b0;
    int          hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 1500000);
        $display("*** FAILED ***");
        $finish;
    end

    // Twister state model
    function automatic void load_seed(input t_word seed_word);
        t_word acc;
        acc = seed_word;
        mt_words[0] = acc;
        for (int i = 1; i < STATE_WORDS; i++) begin
            acc = acc * MULT_69069;
            mt_words[i] = acc;
        end
        mt_next = STATE_WORDS;
    endfunction

    function automatic void regenerate_words();
        t_word y;
        for (int i = 0; i < STATE_WORDS; i++) begin
            y = (mt_words[i] & HIGH_BIT) | (mt_words[(i + 1) % STATE_WORDS] & LOW_BITS);
            mt_words[i] = mt_words[(i + TAP_OFFSET) % STATE_WORDS] ^ (y >> 1)
                          ^ (y[0] ? TWIST_XOR : 32'h0);
        end
        mt_next = 0;
    endfunction

    function automatic t_word next_tempered_word();
        t_word v;
        if (mt_next >= STATE_WORDS) begin
            regenerate_words();
        end
        v = mt_words[mt_next];
        mt_next++;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

    // Raw word for bound 0, otherwise rejection-sampled value below bound
    function automatic t_word draw_bounded(input t_word bound);
        t_word limit;
        t_word v;
        if (bound == 32'h0) begin
            return next_tempered_word();
        end
        limit = (32'h0 - bound) / bound;
        do begin
            v = next_tempered_word();
        end while (v / bound > limit);
        return v % bound;
    endfunction

    function automatic t_word pick_bound();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'h1;
            2, 3: return t_word'($urandom_range(100, 2));
            4: return t_word'(1) << $urandom_range(31);
            5: return t_word'($urandom_range(32'hffff_ffff, 32'h8000_0001));
            6: return t_word'($urandom);
            7: return t_word'($urandom_range(65535, 101));
            8: return t_word'($urandom) >> $urandom_range(31);
            default: return 32'h0;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        err_count++;
    endtask

    // Transfer monitor: predicts on every accepted request and seed write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
                load_seed(cfg_if.seed);
            end
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                awaited_values.push_back(draw_bounded(req_if.bound));
            end
        end
    end

    always @(posedge i_clk) begin : check_value
        t_word want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (awaited_values.size() == 0) begin
                report_error($sformatf("value %h with none pending", rsp_if.value));
            end else begin
                want = awaited_values.pop_front();
                if (rsp_if.value !== want) begin
                    report_error($sformatf("value %h, predicted %h", rsp_if.value, want));
                end
            end
        end
    end

    // Response ready with random stalls and an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start   <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_bound(input t_word bound);
        if ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.bound <= bound;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_values.size() != 0);
    endtask

    task automatic write_seed(input t_word seed_word);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= seed_word;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_seed();
        send_bound(32'h0);
        send_bound(32'h0);
        send_bound(32'h1);
        send_bound(32'd7);
    endtask

    task automatic test_bound_extremes();
        t_word bounds [12];
        bounds = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h7fff_ffff, 32'h8000_0000,
                   32'h8000_0001, 32'hffff_fffe, 32'hffff_ffff, 32'h5555_5555,
                   32'haaaa_aaaa, 32'd1000};
        foreach (bounds[i]) begin
            send_bound(bounds[i]);
        end
    endtask

    task automatic test_seed_writes();
        write_seed(32'h0);
        send_bound(32'h0);
        send_bound(32'd5);
        write_seed(32'hffff_ffff);
        send_bound(32'h0);
        send_bound(32'h8000_0001);
        write_seed(RESET_SEED);
        send_bound(32'h0);
        send_bound(32'd3);
    endtask

    task automatic test_backpressure();
        hold_start <= 1'b1;
        repeat (8) send_bound(pick_bound());
        wait_drained();
        repeat (4) send_bound(32'h0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_seed(t_word'($urandom));
        repeat (PHASE_ITEMS) send_bound(pick_bound());
    endtask

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.bound  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.seed   = '0;
        rsp_if.ready  = 1'b0;
        load_seed(RESET_SEED);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_seed();
        test_bound_extremes();
        test_seed_writes();
        test_backpressure();
        test_random_traffic(12, 50);
        test_random_traffic(50, 12);
        test_random_traffic(0, 0);

        req_if.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (awaited_values.size() != 0 && waited < DRAIN_LIMIT);
        if (awaited_values.size() != 0) begin
            report_error($sformatf("%0d values never arrived", awaited_values.size()));
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
